// ===== hw/rtl/lmbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lmbm_pkg
// shared constants and types of the label map boundary marker
// ----------------------------------------------------------------------------
package lmbm_pkg;

    localparam int LABEL_BITS     = 16;
    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
    localparam int COUNT_BITS     = 12;
    localparam int SIZE_BITS      = 13;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_BITS-1:0] SIZE_MIN      = SIZE_BITS'(2);
    localparam logic [SIZE_BITS-1:0] WIDTH_MAX     = SIZE_BITS'(MAX_WIDTH);
    localparam logic [SIZE_BITS-1:0] HEIGHT_MAX    = SIZE_BITS'(MAX_HEIGHT);
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET   = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET  = SIZE_BITS'(1024);

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        label_t bottom_right;
        label_t top_right;
        count_t win_col;
        count_t win_row;
        logic   has_win;
        logic   frame_last;
    } item_t;

endpackage

// ===== hw/rtl/lmbm_front.sv =====
// ----------------------------------------------------------------------------
// lmbm_front
// raster counters, previous row store and window classification
// ----------------------------------------------------------------------------
module lmbm_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr,
    input  logic                     cfg_index,
    input  logic [12:0]              cfg_data,
    input  logic                     label_valid,
    output logic                     label_ready,
    input  logic [15:0]              label_in,
    output logic                     item_valid,
    input  logic                     item_ready,
    output lmbm_pkg::item_t          item
);
    import lmbm_pkg::*;

    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    logic [SIZE_BITS-1:0]  width_eff;
    logic [SIZE_BITS-1:0]  height_eff;
    count_t                col_reg;
    count_t                col_next;
    count_t                row_reg;
    count_t                row_next;
    logic                  end_col;
    logic                  end_row;
    logic                  accept;
    logic                  a_valid_reg;
    logic                  a_valid_next;
    label_t                a_label_reg;
    count_t                a_col_reg;
    count_t                a_row_reg;
    logic                  a_has_win_reg;
    logic                  a_last_reg;
    label_t                row_store_reg [MAX_WIDTH];
    label_t                row_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < SIZE_MIN)
            width_eff = SIZE_MIN;
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;

        if (height_reg < SIZE_MIN)
            height_eff = SIZE_MIN;
        else if (height_reg > HEIGHT_MAX)
            height_eff = HEIGHT_MAX;
        else
            height_eff = height_reg;
    end

    assign end_col = ({1'b0, col_reg} + SIZE_BITS'(1)) >= width_eff;
    assign end_row = ({1'b0, row_reg} + SIZE_BITS'(1)) >= height_eff;

    assign item_valid  = a_valid_reg;
    assign label_ready = !a_valid_reg || item_ready;
    assign accept      = label_valid && label_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + COUNT_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COUNT_BITS'(1);
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (item_ready)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_label_reg   <= label_in[LABEL_BITS-1:0];
            a_col_reg     <= col_reg - COUNT_BITS'(1);
            a_row_reg     <= row_reg - COUNT_BITS'(1);
            a_has_win_reg <= (col_reg != '0) && (row_reg != '0);
            a_last_reg    <= end_col && end_row;
        end
    end

    // previous row, read before write at the current column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_rd_reg                          <= row_store_reg[col_reg[ADDR_BITS-1:0]];
            row_store_reg[col_reg[ADDR_BITS-1:0]] <= label_in[LABEL_BITS-1:0];
        end
    end

    always_comb
    begin
        item.bottom_right = a_label_reg;
        item.top_right    = row_rd_reg;
        item.win_col      = a_col_reg;
        item.win_row      = a_row_reg;
        item.has_win      = a_has_win_reg;
        item.frame_last   = a_last_reg;
    end

endmodule

// ===== hw/rtl/lmbm_queue.sv =====
// ----------------------------------------------------------------------------
// lmbm_queue
// short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module lmbm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  lmbm_pkg::item_t   push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output lmbm_pkg::item_t   pop_item
);
    import lmbm_pkg::*;

    item_t                      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0]  count_reg;
    logic [QUEUE_CNT_BITS-1:0]  count_next;
    logic                       push;
    logic                       pop;

    assign push_ready = count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hw/rtl/lmbm_back.sv =====
// ----------------------------------------------------------------------------
// lmbm_back
// window comparison, left and upper-left history and result register
// ----------------------------------------------------------------------------
module lmbm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  lmbm_pkg::item_t   item,
    output logic              win_valid,
    input  logic              win_ready,
    output logic [11:0]       win_col,
    output logic [11:0]       win_row,
    output logic              mark_top,
    output logic              mark_right,
    output logic              mark_bottom,
    output logic              mark_left,
    output logic              mark_center,
    output logic              frame_last
);
    import lmbm_pkg::*;

    label_t  left_reg;
    label_t  upper_left_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    pop;
    logic    load;
    logic    eq_top;
    logic    eq_right;
    logic    eq_bottom;
    logic    eq_left;
    logic    alt;
    count_t  col_reg;
    count_t  row_reg;
    logic    top_reg;
    logic    right_reg;
    logic    bottom_reg;
    logic    left_mark_reg;
    logic    center_reg;
    logic    last_reg;

    assign item_ready = !item.has_win || !out_valid_reg || win_ready;
    assign pop        = item_valid && item_ready;
    assign load       = pop && item.has_win;

    assign eq_top    = upper_left_reg == item.top_right;
    assign eq_right  = item.top_right == item.bottom_right;
    assign eq_bottom = item.bottom_right == left_reg;
    assign eq_left   = left_reg == upper_left_reg;
    assign alt       = (eq_top != eq_right) && (eq_right != eq_bottom) &&
                       (eq_bottom != eq_left) && (eq_left != eq_top);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (win_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            upper_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                upper_left_reg <= item.top_right;
                left_reg       <= item.bottom_right;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg       <= item.win_col;
            row_reg       <= item.win_row;
            top_reg       <= !eq_top;
            right_reg     <= !eq_right;
            bottom_reg    <= !eq_bottom;
            left_mark_reg <= !eq_left;
            center_reg    <= alt;
            last_reg      <= item.frame_last;
        end
    end

    assign win_valid   = out_valid_reg;
    assign win_col     = col_reg;
    assign win_row     = row_reg;
    assign mark_top    = top_reg;
    assign mark_right  = right_reg;
    assign mark_bottom = bottom_reg;
    assign mark_left   = left_mark_reg;
    assign mark_center = center_reg;
    assign frame_last  = last_reg;

endmodule

// ===== hw/rtl/label_map_boundary_marker.sv =====
// ----------------------------------------------------------------------------
// label_map_boundary_marker
// 2x2 window region boundary marks over a raster stream of labels
// ----------------------------------------------------------------------------
// Takes one label per clock in raster order unless the output stalls and,
// for every pixel past the first row and column, returns one transaction
// with the window position and its five boundary marks; a result passes the
// row store read register, the queue and the result register. The previous
// row sits in a 4096-entry single-port memory read before write at the
// current column, so one memory access per label sets the rate. A four-entry
// queue separates the front from the result side so either can stall alone.
// The row store has no clearing pass and needs none. The user must write
// frame width and height only while the block is idle; the block does not
// enforce it. Sizes below 2 act as 2 and above 4096 as 4096.
// ----------------------------------------------------------------------------
module label_map_boundary_marker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data,
    input  logic         label_valid,
    output logic         label_ready,
    input  logic [15:0]  label_in,
    output logic         win_valid,
    input  logic         win_ready,
    output logic [11:0]  win_col,
    output logic [11:0]  win_row,
    output logic         mark_top,
    output logic         mark_right,
    output logic         mark_bottom,
    output logic         mark_left,
    output logic         mark_center,
    output logic         frame_last
);
    import lmbm_pkg::*;

    logic   f_valid;
    logic   f_ready;
    item_t  f_item;
    logic   q_valid;
    logic   q_ready;
    item_t  q_item;

    assign cfg_ready = 1'b1;

    lmbm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .label_valid (label_valid),
        .label_ready (label_ready),
        .label_in    (label_in),
        .item_valid  (f_valid),
        .item_ready  (f_ready),
        .item        (f_item)
    );

    lmbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    lmbm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .win_valid   (win_valid),
        .win_ready   (win_ready),
        .win_col     (win_col),
        .win_row     (win_row),
        .mark_top    (mark_top),
        .mark_right  (mark_right),
        .mark_bottom (mark_bottom),
        .mark_left   (mark_left),
        .mark_center (mark_center),
        .frame_last  (frame_last)
    );

endmodule
